// ===== design/llic_pkg.sv =====
`default_nettype none
package llic_pkg;

	typedef logic signed [35:0] sval_t;

	// one normalized sine numerator per leg
	typedef struct packed {
		sval_t s3;
		sval_t s2;
		sval_t s1;
		sval_t s0;
	} leg_set_t;

	typedef enum logic [1:0] {
		LEG_VALID   = 2'd0,
		LEG_RANGE   = 2'd1,
		LEG_SKIPPED = 2'd2
	} leg_status_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_START,
		F_DIV,
		F_NORM,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LEG,
		B_DIV,
		B_ANG,
		B_DONE
	} back_state_t;

	localparam logic [2:0] REG_SPAN_X        = 3'd0;
	localparam logic [2:0] REG_SPAN_Y        = 3'd1;
	localparam logic [2:0] REG_FOOT_OVERHANG = 3'd2;
	localparam logic [2:0] REG_LEG_DROP      = 3'd3;
	localparam logic [2:0] REG_ARM_OFFSET    = 3'd4;
	localparam logic [2:0] REG_ARM_LENGTH    = 3'd5;
	localparam logic [2:0] REG_ANGLE_LIMIT   = 3'd6;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int unsigned ANGLE_MAX = 9000;

	// sine of m/200 degree in Q30, used only to build the angle table
	function automatic longint sine_q30(input int unsigned m);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (longint'(m) * PI_Q30 + 64'd18000) / 64'd36000;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		// alternate signs, denominators (2n)(2n+1) for n = 1..9
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd342;
		sum = sum - longint'(term);
		return sum;
	endfunction

endpackage
`default_nettype wire

// ===== design/llic_div.sv =====
`default_nettype none
module llic_div #(
	parameter int QW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QW+15:0]    dividend,
	input  logic [15:0]       divisor,
	output logic              busy,
	output logic              done,
	output logic [QW-1:0]     quotient
);

	localparam int QP = QW + (QW % 2);
	localparam int CYC = QP / 2;
	localparam int CW = $clog2(CYC + 1);

	logic [QP+15:0] padded;
	logic [15:0]    rem_q;
	logic [QP-1:0]  sh_q;
	logic [15:0]    div_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [15:0]    rem_d;
	logic [QP-1:0]  sh_d;
	logic [16:0]    trial;

	assign padded = (QP + 16)'(dividend);

	// two restoring steps per cycle; quotient bits shift in behind the dividend
	always_comb begin
		rem_d = rem_q;
		sh_d = sh_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_d, sh_d[QP-1]};
			sh_d = {sh_d[QP-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_d = 16'(trial - {1'b0, div_q});
				sh_d[0] = 1'b1;
			end else begin
				rem_d = trial[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= padded[QP+15:QP];
			sh_q <= padded[QP-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			sh_q <= sh_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = sh_q[QW-1:0];

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");

endmodule
`default_nettype wire

// ===== design/llic_fifo.sv =====
`default_nettype none
module llic_fifo #(
	parameter int W = 144,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");

endmodule
`default_nettype wire

// ===== design/llic_front.sv =====
`default_nettype none
module llic_front import llic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] range_one,
	input  logic [15:0] range_two,
	input  logic [15:0] range_three,
	input  logic [15:0] range_four,
	input  logic [15:0] span_x,
	input  logic [15:0] foot_overhang,
	input  logic [15:0] leg_drop,
	input  logic [15:0] arm_offset,
	input  logic        q_full,
	output logic        q_push,
	output leg_set_t    q_data
);

	front_state_t state_q, state_d;

	logic        buf_valid_q;
	logic [15:0] buf_r_q [4];
	logic        accept;
	logic        take;

	logic [15:0] m01, m23, mx;
	logic [15:0] h0, h1, h2;
	logic signed [16:0] d;
	logic [15:0] h0_s1, h1_s1, h2_s1;
	logic signed [16:0] d_s1;
	logic [15:0] absd;
	logic [31:0] mag_s2;
	logic        neg_s2;
	logic [15:0] sx;

	logic        div_start, div_busy, div_done;
	logic [47:0] div_dividend;
	logic [31:0] div_q;

	logic signed [34:0] eq, e;
	logic signed [34:0] z_d [4];
	logic signed [34:0] z_s3 [4];
	logic signed [34:0] mn01, mn23, mn_d, mn_q;
	logic signed [16:0] adj_q;

	assign accept = sample_valid && !buf_valid_q;
	assign sample_stall = buf_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (buf_valid_q) state_d = F_MUL;
			F_MUL:   state_d = F_START;
			F_START: state_d = F_DIV;
			F_DIV:   if (div_done) state_d = F_NORM;
			F_NORM:  state_d = F_PUSH;
			F_PUSH:  if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		take = (state_q == F_IDLE) && buf_valid_q;
		div_start = (state_q == F_START);
		q_push = (state_q == F_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			buf_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				buf_valid_q <= 1'b1;
			else if (take)
				buf_valid_q <= 1'b0;
		end
	end

	// heights relative to the highest reading
	always_comb begin
		m01 = (buf_r_q[1] > buf_r_q[0]) ? buf_r_q[1] : buf_r_q[0];
		m23 = (buf_r_q[3] > buf_r_q[2]) ? buf_r_q[3] : buf_r_q[2];
		mx = (m23 > m01) ? m23 : m01;
		h0 = mx - buf_r_q[0];
		h1 = mx - buf_r_q[1];
		h2 = mx - buf_r_q[2];
		d = $signed({1'b0, h1}) - $signed({1'b0, h0});
	end

	assign absd = d_s1[16] ? 16'(-d_s1) : d_s1[15:0];
	assign sx = (span_x == 16'd0) ? 16'd1 : span_x;
	assign div_dividend = 48'(mag_s2 + 32'(sx[15:1]));

	llic_div #(.QW(32)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (sx),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// slope term carries the sign of the height difference, ties away from zero
	always_comb begin
		eq = $signed({3'b0, div_q});
		e = neg_s2 ? -eq : eq;
		z_d[0] = $signed({19'b0, h0_s1}) - e;
		z_d[1] = $signed({19'b0, h1_s1}) + e;
		z_d[2] = $signed({19'b0, h2_s1}) - e;
		z_d[3] = $signed({19'b0, h2_s1}) + 35'(d_s1) + e;
		mn01 = (z_s3[1] < z_s3[0]) ? z_s3[1] : z_s3[0];
		mn23 = (z_s3[3] < z_s3[2]) ? z_s3[3] : z_s3[2];
		mn_d = (mn23 < mn01) ? mn23 : mn01;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_r_q[0] <= range_one;
			buf_r_q[1] <= range_two;
			buf_r_q[2] <= range_three;
			buf_r_q[3] <= range_four;
		end
		if (take) begin
			h0_s1 <= h0;
			h1_s1 <= h1;
			h2_s1 <= h2;
			d_s1 <= d;
		end
		if (state_q == F_MUL) begin
			mag_s2 <= 32'(absd) * 32'(foot_overhang);
			neg_s2 <= d_s1[16];
		end
		if (state_q == F_DIV && div_done)
			z_s3 <= z_d;
		if (state_q == F_NORM) begin
			mn_q <= mn_d;
			adj_q <= $signed({1'b0, arm_offset}) - $signed({1'b0, leg_drop});
		end
	end

	assign q_data.s0 = 36'(z_s3[0]) - 36'(mn_q) + 36'(adj_q);
	assign q_data.s1 = 36'(z_s3[1]) - 36'(mn_q) + 36'(adj_q);
	assign q_data.s2 = 36'(z_s3[2]) - 36'(mn_q) + 36'(adj_q);
	assign q_data.s3 = 36'(z_s3[3]) - 36'(mn_q) + 36'(adj_q);

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == F_DIV) else $error("slope divider busy outside divide");

endmodule
`default_nettype wire

// ===== design/llic_back.sv =====
`default_nettype none
module llic_back import llic_pkg::*; #(
	parameter int TB = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  leg_set_t           q_data,
	input  logic [15:0]        arm_length,
	input  logic [13:0]        angle_limit,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [14:0] angle_one,
	output logic signed [14:0] angle_two,
	output logic signed [14:0] angle_three,
	output logic signed [14:0] angle_four,
	output logic [1:0]         status_one,
	output logic [1:0]         status_two,
	output logic [1:0]         status_three,
	output logic [1:0]         status_four,
	output logic               no_land
);

	localparam int QW = TB + 1;
	localparam int TSIZE = (1 << TB) + 1;

	typedef logic [TSIZE-1:0][13:0] tab_t;

	// smallest angle whose midpoint sine exceeds each table step
	function automatic tab_t build_tab();
		tab_t t;
		int unsigned a;
		longint v;
		t = '0;
		a = 0;
		for (int k = 0; k < TSIZE; k++) begin
			v = longint'(k) << (30 - TB);
			while (a < ANGLE_MAX && sine_q30(2 * a + 1) <= v)
				a++;
			t[k] = 14'(a);
		end
		return t;
	endfunction

	localparam tab_t ASIN_TAB = build_tab();

	back_state_t state_q, state_d;

	sval_t       s_q [4];
	logic [1:0]  leg_q;
	logic        stop_q;
	logic        nl_q;
	logic        neg_q;
	logic [13:0] rd_q;
	logic signed [14:0] ang_q [4];
	leg_status_t sts_q [4];

	logic               result_valid_q;
	logic signed [14:0] angle_q [4];
	logic [1:0]         status_q [4];
	logic               no_land_q;

	sval_t        cur;
	logic [15:0]  arm;
	sval_t        armx;
	logic         in_rng;
	logic [15:0]  as;
	logic signed [14:0] aval, ang;
	logic         over;
	logic         div_start, div_busy, div_done;
	logic [QW+15:0] div_dividend;
	logic [QW-1:0]  div_q;
	logic         leg_adv;
	logic         out_ld;

	always_comb begin
		cur = s_q[leg_q];
		arm = (arm_length == 16'd0) ? 16'd1 : arm_length;
		armx = $signed({20'b0, arm});
		in_rng = (cur >= -armx) && (cur <= armx);
		as = cur[35] ? 16'(-cur) : cur[15:0];
		div_dividend = ((QW + 16)'(as) << TB) + (QW + 16)'(arm[15:1]);
		aval = $signed({1'b0, rd_q});
		ang = neg_q ? -aval : aval;
		over = 16'(ang) > $signed({2'b0, angle_limit});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_d = B_LEG;
			B_LEG: begin
				if (!stop_q && in_rng)
					state_d = B_DIV;
				else if (leg_q == 2'd3)
					state_d = B_DONE;
			end
			B_DIV:  if (div_done) state_d = B_ANG;
			B_ANG:  state_d = (leg_q == 2'd3) ? B_DONE : B_LEG;
			B_DONE: if (!result_valid_q || !result_stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == B_IDLE) && !q_empty;
		div_start = (state_q == B_LEG) && !stop_q && in_rng;
		leg_adv = ((state_q == B_LEG) && !div_start) || (state_q == B_ANG);
		out_ld = (state_q == B_DONE) && (!result_valid_q || !result_stall);
	end

	llic_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (arm),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			leg_q <= '0;
			stop_q <= 1'b0;
			nl_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				leg_q <= '0;
				stop_q <= 1'b0;
				nl_q <= 1'b0;
			end else if (leg_adv) begin
				leg_q <= leg_q + 2'd1;
			end
			if (state_q == B_ANG && over) begin
				stop_q <= 1'b1;
				nl_q <= 1'b1;
			end
			if (out_ld)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			s_q[0] <= q_data.s0;
			s_q[1] <= q_data.s1;
			s_q[2] <= q_data.s2;
			s_q[3] <= q_data.s3;
		end
		if (state_q == B_LEG) begin
			neg_q <= cur[35];
			if (stop_q) begin
				ang_q[leg_q] <= '0;
				sts_q[leg_q] <= LEG_SKIPPED;
			end else if (!in_rng) begin
				ang_q[leg_q] <= '0;
				sts_q[leg_q] <= LEG_RANGE;
			end
		end
		if (state_q == B_DIV && div_done)
			rd_q <= ASIN_TAB[div_q];
		if (state_q == B_ANG) begin
			ang_q[leg_q] <= ang;
			sts_q[leg_q] <= LEG_VALID;
		end
		if (out_ld) begin
			for (int i = 0; i < 4; i++) begin
				angle_q[i] <= ang_q[i];
				status_q[i] <= sts_q[i];
			end
			no_land_q <= nl_q;
		end
	end

	assign result_valid = result_valid_q;
	assign angle_one = angle_q[0];
	assign angle_two = angle_q[1];
	assign angle_three = angle_q[2];
	assign angle_four = angle_q[3];
	assign status_one = status_q[0];
	assign status_two = status_q[1];
	assign status_three = status_q[2];
	assign status_four = status_q[3];
	assign no_land = no_land_q;

	a_ang_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ANG |-> $past(state_q) == B_DIV) else $error("angle step without divide");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == B_DIV) else $error("arm divider busy outside divide");

endmodule
`default_nettype wire

// ===== design/landing_leg_incline_check_unit.sv =====
// channel   direction  handshake                   payload
// sample    in         sample_valid/sample_stall   range_one..range_four
// result    out        result_valid/result_stall   angle_*, status_*, no_land
// config    in         wr_en (no wait)             wr_index, wr_data
//
// Front end: each sample passes the multiply, start, slope divide, normalize and push states;
// one further sample can wait in the input buffer. Back end: each transaction pops the queue,
// visits every leg, and runs the arm divide and angle step for each leg evaluated in range.
// The slower side sets the sustained rate: the back end once three or more legs are evaluated.
// Asynchronous active-low reset restores the register defaults and empties the queue.
// A stalled result holds in its output register while the next transaction proceeds.
`default_nettype none
module landing_leg_incline_check_unit import llic_pkg::*; #(
	parameter int ASIN_TABLE_BITS = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [15:0]        range_one,
	input  logic [15:0]        range_two,
	input  logic [15:0]        range_three,
	input  logic [15:0]        range_four,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [14:0] angle_one,
	output logic signed [14:0] angle_two,
	output logic signed [14:0] angle_three,
	output logic signed [14:0] angle_four,
	output logic [1:0]         status_one,
	output logic [1:0]         status_two,
	output logic [1:0]         status_three,
	output logic [1:0]         status_four,
	output logic               no_land,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data
);

	logic [15:0] span_x_q;
	logic [15:0] foot_overhang_q;
	logic [15:0] leg_drop_q;
	logic [15:0] arm_offset_q;
	logic [15:0] arm_length_q;
	logic [13:0] angle_limit_q;

	logic     q_push, q_full, q_pop, q_empty;
	leg_set_t q_wdata, q_rdata;

	// sensor spacing along y cancels out of the plane fit and is not kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_x_q <= 16'd1664;
			foot_overhang_q <= 16'd768;
			leg_drop_q <= 16'd1280;
			arm_offset_q <= 16'd896;
			arm_length_q <= 16'd768;
			angle_limit_q <= 14'd3000;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SPAN_X:        span_x_q <= wr_data;
				REG_SPAN_Y:        ;
				REG_FOOT_OVERHANG: foot_overhang_q <= wr_data;
				REG_LEG_DROP:      leg_drop_q <= wr_data;
				REG_ARM_OFFSET:    arm_offset_q <= wr_data;
				REG_ARM_LENGTH:    arm_length_q <= wr_data;
				REG_ANGLE_LIMIT:   angle_limit_q <= wr_data[13:0];
				default:           ;
			endcase
		end
	end

	llic_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.range_one     (range_one),
		.range_two     (range_two),
		.range_three   (range_three),
		.range_four    (range_four),
		.span_x        (span_x_q),
		.foot_overhang (foot_overhang_q),
		.leg_drop      (leg_drop_q),
		.arm_offset    (arm_offset_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	llic_fifo #(.W($bits(leg_set_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	llic_back #(.TB(ASIN_TABLE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_data       (q_rdata),
		.arm_length   (arm_length_q),
		.angle_limit  (angle_limit_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.angle_one    (angle_one),
		.angle_two    (angle_two),
		.angle_three  (angle_three),
		.angle_four   (angle_four),
		.status_one   (status_one),
		.status_two   (status_two),
		.status_three (status_three),
		.status_four  (status_four),
		.no_land      (no_land)
	);

endmodule
`default_nettype wire
